### src/cstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Call stack trace tracker package
// Shared sizes, result kinds and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package cstt_pkg;

	localparam int STACK_DEPTH   = 32;
	localparam int CONTEXT_SLOTS = 16;
	localparam int SLOT_W        = 4;
	localparam int LVL_W         = $clog2(STACK_DEPTH);
	localparam int DEPTH_W       = 6;
	localparam int MEM_AW        = SLOT_W + LVL_W;
	localparam int MEM_DEPTH     = CONTEXT_SLOTS * STACK_DEPTH;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_START  = 3'd0;
	localparam kind_t KIND_ENTRY  = 3'd1;
	localparam kind_t KIND_RETURN = 3'd2;
	localparam kind_t KIND_LEVEL  = 3'd3;
	localparam kind_t KIND_DONE   = 3'd4;

	localparam logic REQ_ENTRY  = 1'b0;
	localparam logic REQ_RETURN = 1'b1;

	typedef struct packed {
		logic  load_in;
		logic  create;
		logic  clr_step;
		logic  kill;
		logic  push;
		logic  rd_top;
		logic  pop;
		logic  rd_walk;
		logic  cnt_clr;
		logic  cnt_inc;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
	} cmd_t;

	typedef struct packed {
		logic enabled;
		logic req_type;
		logic root;
		logic active;
		logic depth_zero;
		logic depth_one;
		logic depth_full;
		logic addr_match;
		logic cnt_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### src/cstt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Call stack trace tracker channels
// Request channel (function entry/return) and result channel.
// ----------------------------------------------------------------------------
interface cstt_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  ctx_slot;
	logic [63:0] func_addr;
	logic [31:0] func_id;
	logic        func_is_root;
	logic [63:0] timestamp;
	logic [63:0] return_value;

	modport source (output valid, req_type, ctx_slot, func_addr, func_id, func_is_root,
		timestamp, return_value, input ready);
	modport sink (input valid, req_type, ctx_slot, func_addr, func_id, func_is_root,
		timestamp, return_value, output ready);
endinterface

interface cstt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  out_slot;
	logic [5:0]  level;
	logic [31:0] seq_id;
	logic [63:0] out_addr;
	logic [31:0] out_func_id;
	logic [63:0] event_time;
	logic [63:0] duration;
	logic [63:0] origin_time;
	logic [63:0] out_return_value;
	logic        last;

	modport source (output valid, kind, out_slot, level, seq_id, out_addr, out_func_id,
		event_time, duration, origin_time, out_return_value, last, input ready);
	modport sink (input valid, kind, out_slot, level, seq_id, out_addr, out_func_id,
		event_time, duration, origin_time, out_return_value, last, output ready);
endinterface
`default_nettype wire

### src/cstt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Call stack trace tracker controller
// Sequences decode, level clear, push, pop and the done walk.
// ----------------------------------------------------------------------------
module cstt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire cstt_pkg::sts_t sts,
	output cstt_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_CLEAR, S_START, S_PUSH, S_CMP, S_WRD, S_WEMIT, S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.enabled) begin
					state_d = S_IDLE;
				end else if (sts.req_type == cstt_pkg::REQ_ENTRY) begin
					if (!sts.active) begin
						if (sts.root) begin
							cmd.create  = 1'b1;
							cmd.cnt_clr = 1'b1;
							state_d     = S_CLEAR;
						end else begin
							state_d = S_IDLE;
						end
					end else if (sts.depth_full) begin
						state_d = S_IDLE;
					end else if (sts.depth_zero && !sts.root) begin
						cmd.kill = 1'b1;
						state_d  = S_IDLE;
					end else begin
						state_d = S_PUSH;
					end
				end else begin
					if (!sts.active || sts.depth_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_top = 1'b1;
						state_d    = S_CMP;
					end
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.cnt_last) state_d = S_START;
			end
			S_START: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = cstt_pkg::KIND_START;
					state_d       = S_PUSH;
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = cstt_pkg::KIND_ENTRY;
					cmd.emit_last = 1'b1;
					cmd.push      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CMP: begin
				if (!sts.addr_match) begin
					cmd.kill = 1'b1;
					state_d  = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = cstt_pkg::KIND_RETURN;
					cmd.emit_last = !sts.depth_one;
					cmd.pop       = 1'b1;
					if (sts.depth_one) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_WRD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_WRD: begin
				cmd.rd_walk = 1'b1;
				state_d     = S_WEMIT;
			end
			S_WEMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = cstt_pkg::KIND_LEVEL;
					cmd.cnt_inc   = 1'b1;
					state_d       = sts.cnt_last ? S_DONE : S_WRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = cstt_pkg::KIND_DONE;
					cmd.emit_last = 1'b1;
					cmd.kill      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### src/cstt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Call stack trace tracker datapath
// Per-slot record registers, level memory, walk counter and result register.
// ----------------------------------------------------------------------------
module cstt_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           cfg_wdata,
	cstt_req_if.sink            item_in,
	cstt_rsp_if.source          item_out,
	input  wire cstt_pkg::cmd_t cmd,
	output cstt_pkg::sts_t      sts
);

	localparam int SW = cstt_pkg::SLOT_W;
	localparam int LW = cstt_pkg::LVL_W;
	localparam int DW = cstt_pkg::DEPTH_W;
	localparam int AW = cstt_pkg::MEM_AW;

	logic enabled_q;

	logic          req_q;
	logic [SW-1:0] slot_q;
	logic [63:0]   addr_q;
	logic [31:0]   fid_q;
	logic          root_q;
	logic [63:0]   ts_q;
	logic [63:0]   rv_q;

	logic          active_q [cstt_pkg::CONTEXT_SLOTS];
	logic [DW-1:0] depth_q  [cstt_pkg::CONTEXT_SLOTS];
	logic [31:0]   seq_q    [cstt_pkg::CONTEXT_SLOTS];
	logic [63:0]   start_q  [cstt_pkg::CONTEXT_SLOTS];

	logic [DW-1:0] cnt_q;

	logic [127:0] mem [cstt_pkg::MEM_DEPTH];
	logic [127:0] rd_q;

	logic          out_valid_q;
	cstt_pkg::kind_t kind_q;
	logic [SW-1:0] oslot_q;
	logic [5:0]    level_q;
	logic [31:0]   oseq_q;
	logic [63:0]   oaddr_q;
	logic [31:0]   ofid_q;
	logic [63:0]   etime_q;
	logic [63:0]   dur_q;
	logic [63:0]   ostart_q;
	logic [63:0]   orv_q;
	logic          last_q;

	logic [DW-1:0] cur_depth;
	logic [DW-1:0] top_depth;
	logic [63:0]   ret_dur;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [127:0]  wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign cur_depth = depth_q[slot_q];
	assign top_depth = cur_depth - DW'(1);
	assign ret_dur   = ts_q - rd_q[63:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {slot_q, cnt_q[LW-1:0]};
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.push) begin
			wr_en   = 1'b1;
			wr_addr = {slot_q, cur_depth[LW-1:0]};
			wr_data = {addr_q, ts_q};
		end else if (cmd.pop) begin
			wr_en   = 1'b1;
			wr_addr = {slot_q, top_depth[LW-1:0]};
			wr_data = {rd_q[127:64], ret_dur};
		end
		rd_en   = cmd.rd_top | cmd.rd_walk;
		rd_addr = cmd.rd_top ? {slot_q, top_depth[LW-1:0]} : {slot_q, cnt_q[LW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_comb begin
		sts.enabled    = enabled_q;
		sts.req_type   = req_q;
		sts.root       = root_q;
		sts.active     = active_q[slot_q];
		sts.depth_zero = (cur_depth == '0);
		sts.depth_one  = (cur_depth == DW'(1));
		sts.depth_full = (cur_depth == DW'(cstt_pkg::STACK_DEPTH));
		sts.addr_match = (rd_q[127:64] == addr_q);
		sts.cnt_last   = (cnt_q == DW'(cstt_pkg::STACK_DEPTH - 1));
		sts.out_free   = !out_valid_q || item_out.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q  <= item_in.req_type;
			slot_q <= item_in.ctx_slot;
			addr_q <= item_in.func_addr;
			fid_q  <= item_in.func_id;
			root_q <= item_in.func_is_root;
			ts_q   <= item_in.timestamp;
			rv_q   <= item_in.return_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cstt_pkg::CONTEXT_SLOTS; i++) active_q[i] <= 1'b0;
		end else if (cmd.create) begin
			active_q[slot_q] <= 1'b1;
		end else if (cmd.kill) begin
			active_q[slot_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create) begin
			depth_q[slot_q] <= '0;
			seq_q[slot_q]   <= 32'd1;
			start_q[slot_q] <= ts_q;
		end else if (cmd.push) begin
			depth_q[slot_q] <= cur_depth + DW'(1);
			seq_q[slot_q]   <= seq_q[slot_q] + 32'd1;
		end else if (cmd.pop) begin
			depth_q[slot_q] <= top_depth;
			seq_q[slot_q]   <= seq_q[slot_q] + 32'd1;
		end
		if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.clr_step || cmd.cnt_inc) begin
			cnt_q <= cnt_q + DW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.emit_kind;
			oslot_q  <= slot_q;
			last_q   <= cmd.emit_last;
			level_q  <= '0;
			oseq_q   <= '0;
			oaddr_q  <= '0;
			ofid_q   <= '0;
			etime_q  <= '0;
			dur_q    <= '0;
			ostart_q <= '0;
			orv_q    <= '0;
			unique case (cmd.emit_kind)
				cstt_pkg::KIND_START: begin
					etime_q <= ts_q;
				end
				cstt_pkg::KIND_ENTRY: begin
					level_q <= cur_depth;
					oseq_q  <= seq_q[slot_q];
					oaddr_q <= addr_q;
					ofid_q  <= fid_q;
					etime_q <= ts_q;
				end
				cstt_pkg::KIND_RETURN: begin
					level_q <= top_depth;
					oseq_q  <= seq_q[slot_q];
					oaddr_q <= addr_q;
					ofid_q  <= fid_q;
					etime_q <= ts_q;
					dur_q   <= ret_dur;
					orv_q   <= rv_q;
				end
				cstt_pkg::KIND_LEVEL: begin
					level_q <= cnt_q;
					oaddr_q <= rd_q[127:64];
					dur_q   <= rd_q[63:0];
				end
				cstt_pkg::KIND_DONE: begin
					oseq_q   <= seq_q[slot_q];
					etime_q  <= ts_q;
					ostart_q <= start_q[slot_q];
				end
				default: begin
				end
			endcase
		end
	end

	assign item_out.valid            = out_valid_q;
	assign item_out.kind             = kind_q;
	assign item_out.out_slot         = oslot_q;
	assign item_out.level            = level_q;
	assign item_out.seq_id           = oseq_q;
	assign item_out.out_addr         = oaddr_q;
	assign item_out.out_func_id      = ofid_q;
	assign item_out.event_time       = etime_q;
	assign item_out.duration         = dur_q;
	assign item_out.origin_time      = ostart_q;
	assign item_out.out_return_value = orv_q;
	assign item_out.last             = last_q;

endmodule
`default_nettype wire

### src/call_stack_trace_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item is decoded, then its result is emitted for a plain entry or
//   return; a root entry clears 32 levels first, then emits start and entry results.
// A return to depth 0 walks the levels one at a time, then emits the done result.
// A new item is accepted only once the last one is through (accept, decode, emit);
//   ignored items end after decode; result stalls hold the flow.
// Reset: tracing disabled, all records inactive; a record clears its own levels.
// ----------------------------------------------------------------------------
// Call stack trace tracker
// Shadow call stack per context slot, reporting entries, returns and call trees.
// ----------------------------------------------------------------------------
module call_stack_trace_tracker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	cstt_req_if.sink   item_in,
	cstt_rsp_if.source item_out
);

	cstt_pkg::cmd_t cmd;
	cstt_pkg::sts_t sts;

	cstt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item_in.valid),
		.in_ready(item_in.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cstt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_in  (item_in),
		.item_out (item_out),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire

### src/cstt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Call stack trace tracker checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module cstt_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] kind,
	input wire logic       last
);

	// one item in flight: the request side closes right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while an item is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
		else $error("stalled result changed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cstt_pkg::KIND_DONE |-> last)
		else $error("done result without last");

	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == cstt_pkg::KIND_START || kind == cstt_pkg::KIND_LEVEL) |-> !last)
		else $error("start or level result marked last");

endmodule

bind call_stack_trace_tracker cstt_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (item_in.valid),
	.in_ready (item_in.ready),
	.out_valid(item_out.valid),
	.out_ready(item_out.ready),
	.kind     (item_out.kind),
	.last     (item_out.last)
);
`default_nettype wire

### dv/call_stack_trace_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Call stack trace tracker testbench
// Drives function entry/return items through a shadow-stack predictor and
// checks every result field against the expected result queue.
// ----------------------------------------------------------------------------
module call_stack_trace_tracker_tb;

	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  ctx_slot;
		logic [63:0] func_addr;
		logic [31:0] func_id;
		logic        func_is_root;
		logic [63:0] timestamp;
		logic [63:0] return_value;
	} call_t;

	typedef struct packed {
		cstt_pkg::kind_t kind;
		logic [3:0]  out_slot;
		logic [5:0]  level;
		logic [31:0] seq_id;
		logic [63:0] out_addr;
		logic [31:0] out_func_id;
		logic [63:0] event_time;
		logic [63:0] duration;
		logic [63:0] origin_time;
		logic [63:0] out_return_value;
		logic        last;
	} trace_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	cstt_req_if item_in ();
	cstt_rsp_if item_out ();

	call_stack_trace_tracker DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item_in(item_in.sink), .item_out(item_out.source)
	);

	always #5 clk = ~clk;

	// shadow copy of the block state
	logic        trace_on;
	logic        rec_live [cstt_pkg::CONTEXT_SLOTS];
	logic [5:0]  rec_depth [cstt_pkg::CONTEXT_SLOTS];
	logic [31:0] rec_seq [cstt_pkg::CONTEXT_SLOTS];
	logic [63:0] rec_start [cstt_pkg::CONTEXT_SLOTS];
	logic [63:0] lvl_addr [cstt_pkg::CONTEXT_SLOTS][cstt_pkg::STACK_DEPTH];
	logic [63:0] lvl_time [cstt_pkg::CONTEXT_SLOTS][cstt_pkg::STACK_DEPTH];

	call_t  pending_calls[$];
	trace_t expected_traces[$];
	int     errors = 0;
	int     cycles = 0;
	int     src_idle_pct = 0;
	int     snk_idle_pct = 0;
	bit     feeding = 1'b0;

	function automatic trace_t blank(cstt_pkg::kind_t k, logic [3:0] s);
		trace_t t;
		t = '0;
		t.kind = k;
		t.out_slot = s;
		return t;
	endfunction

	task automatic predict_call(input call_t c);
		trace_t    t;
		trace_t    outs[$];
		int        s;
		int        d;
		if (!trace_on) return;
		s = c.ctx_slot;
		if (c.req_type == cstt_pkg::REQ_ENTRY) begin
			if (!rec_live[s]) begin
				if (!c.func_is_root) return;
				rec_live[s] = 1'b1;
				rec_depth[s] = '0;
				rec_seq[s] = 32'd1;
				rec_start[s] = c.timestamp;
				for (int i = 0; i < cstt_pkg::STACK_DEPTH; i++) begin
					lvl_addr[s][i] = '0;
					lvl_time[s][i] = '0;
				end
				t = blank(cstt_pkg::KIND_START, c.ctx_slot);
				t.event_time = c.timestamp;
				outs.push_back(t);
			end
			d = rec_depth[s];
			if (d < cstt_pkg::STACK_DEPTH) begin
				if (d == 0 && !c.func_is_root) begin
					rec_live[s] = 1'b0;
					return;
				end
				t = blank(cstt_pkg::KIND_ENTRY, c.ctx_slot);
				t.level = 6'(d);
				t.seq_id = rec_seq[s];
				t.out_addr = c.func_addr;
				t.out_func_id = c.func_id;
				t.event_time = c.timestamp;
				outs.push_back(t);
				rec_seq[s]++;
				lvl_addr[s][d] = c.func_addr;
				lvl_time[s][d] = c.timestamp;
				rec_depth[s] = 6'(d + 1);
			end
		end else begin
			if (!rec_live[s] || rec_depth[s] == 0) return;
			d = rec_depth[s] - 1;
			if (lvl_addr[s][d] != c.func_addr) begin
				rec_live[s] = 1'b0;
				return;
			end
			t = blank(cstt_pkg::KIND_RETURN, c.ctx_slot);
			t.level = 6'(d);
			t.seq_id = rec_seq[s];
			t.out_addr = c.func_addr;
			t.out_func_id = c.func_id;
			t.event_time = c.timestamp;
			t.duration = c.timestamp - lvl_time[s][d];
			t.out_return_value = c.return_value;
			outs.push_back(t);
			lvl_time[s][d] = c.timestamp - lvl_time[s][d];
			rec_depth[s] = 6'(d);
			rec_seq[s]++;
			if (d == 0) begin
				for (int i = 0; i < cstt_pkg::STACK_DEPTH; i++) begin
					t = blank(cstt_pkg::KIND_LEVEL, c.ctx_slot);
					t.level = 6'(i);
					t.out_addr = lvl_addr[s][i];
					t.duration = lvl_time[s][i];
					outs.push_back(t);
				end
				t = blank(cstt_pkg::KIND_DONE, c.ctx_slot);
				t.seq_id = rec_seq[s];
				t.event_time = c.timestamp;
				t.origin_time = rec_start[s];
				outs.push_back(t);
				rec_live[s] = 1'b0;
			end
		end
		if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i]) expected_traces.push_back(outs[i]);
	endtask

	// driver: hold the item until accepted, then advance
	always @(posedge clk) begin
		if (arst_n) begin
			if (!item_in.valid || item_in.ready) begin
				if (item_in.valid) predict_call(pending_calls.pop_front());
				if (feeding && pending_calls.size() > 0 &&
						$urandom_range(99, 0) >= src_idle_pct) begin
					item_in.valid <= 1'b1;
					{item_in.req_type, item_in.ctx_slot, item_in.func_addr, item_in.func_id,
						item_in.func_is_root, item_in.timestamp, item_in.return_value}
						<= pending_calls[0];
				end else begin
					item_in.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		trace_t got;
		trace_t exp;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (item_out.valid && item_out.ready) begin
				got = {item_out.kind, item_out.out_slot, item_out.level, item_out.seq_id,
					item_out.out_addr, item_out.out_func_id, item_out.event_time,
					item_out.duration, item_out.origin_time, item_out.out_return_value,
					item_out.last};
				if (expected_traces.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					exp = expected_traces.pop_front();
					if (got !== exp) begin
						errors++;
						if (errors <= 10) $display("mismatch exp %h got %h", exp, got);
					end
				end
			end
			item_out.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
		end
	end

	function automatic call_t mk(logic rt, logic [3:0] s, logic [63:0] a, logic root,
			logic [63:0] ts);
		call_t c;
		c.req_type = rt;
		c.ctx_slot = s;
		c.func_addr = a;
		c.func_id = $urandom;
		c.func_is_root = root;
		c.timestamp = ts;
		c.return_value = {$urandom, $urandom};
		return c;
	endfunction

	function automatic logic [63:0] r64();
		return {$urandom, $urandom};
	endfunction

	task automatic drain();
		while (pending_calls.size() > 0 || item_in.valid || expected_traces.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_trace(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		trace_on = v;
	endtask

	// well-formed call tree in one slot with random content, some breakage
	task automatic queue_tree(input logic [3:0] s, input int depth, input bit broken);
		logic [63:0] addrs[$];
		logic [63:0] ts;
		ts = r64();
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, s, r64(), 1'b1, ts));
		addrs.push_back(pending_calls[$].func_addr);
		for (int i = 1; i < depth; i++) begin
			ts = ts + 64'($urandom_range(1000, 0));
			pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, s, r64(),
				1'($urandom_range(1, 0)), ts));
			addrs.push_back(pending_calls[$].func_addr);
		end
		while (addrs.size() > 0) begin
			ts = ts + 64'($urandom_range(5000, 0));
			pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, s,
				(broken && $urandom_range(9, 0) == 0) ? r64() : addrs.pop_back(),
				1'($urandom_range(1, 0)), ts));
		end
	endtask

	initial begin
		logic [63:0] a;
		item_in.valid = 1'b0;
		item_in.req_type = 1'b0;
		item_in.ctx_slot = '0;
		item_in.func_addr = '0;
		item_in.func_id = '0;
		item_in.func_is_root = 1'b0;
		item_in.timestamp = '0;
		item_in.return_value = '0;
		item_out.ready = 1'b0;
		trace_on = 1'b0;
		foreach (rec_live[i]) begin
			rec_live[i] = 1'b0;
			rec_depth[i] = '0;
			rec_seq[i] = '0;
			rec_start[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// tracing off: everything ignored
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd0, '1, 1'b1, 64'd5));
		pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd0, '1, 1'b1, 64'd9));
		feeding = 1'b1;
		drain();
		set_trace(1'b1);

		// directed: drop, non-root delete, mismatch, return without record / at depth zero,
		// timestamp wrap on duration
		src_idle_pct = 37; snk_idle_pct = 49;
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd15, 64'd1, 1'b0, 64'd1));
		pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd15, 64'd1, 1'b0, 64'd1));
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd15, '1, 1'b1, '1));
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd15, 64'd0, 1'b0, 64'd3));
		pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd15, 64'd0, 1'b1, 64'd2));
		pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd15, '1, 1'b0, 64'd4));
		pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd15, '1, 1'b0, 64'd4));
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd15, 64'd7, 1'b0, 64'd4));
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd3, 64'd7, 1'b1, 64'd4));
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd3, 64'd8, 1'b0, 64'd6));
		pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd3, 64'd9, 1'b0, 64'd7));
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd3, 64'd8, 1'b0, 64'd6));
		// full stack: 33 entries, the last ignored, then unwind all
		pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd9, 64'd100, 1'b1, 64'd10));
		for (int i = 1; i <= cstt_pkg::STACK_DEPTH; i++)
			pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd9, 64'd100 + 64'(i), 1'b0,
				64'd10 + 64'(i)));
		for (int i = cstt_pkg::STACK_DEPTH - 1; i >= 0; i--)
			pending_calls.push_back(mk(cstt_pkg::REQ_RETURN, 4'd9, 64'd100 + 64'(i), 1'b0,
				64'd90 + 64'(i)));
		drain();

		// sequence wrap is reached only after 2^32 events; counted by prediction
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 49 : 0;
			snk_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 37 : 0;
			for (int n = 0; n < 110; ) begin
				int pick;
				pick = $urandom_range(9, 0);
				if (pick < 6) begin
					int dep;
					dep = ($urandom_range(9, 0) == 0) ?
						$urandom_range(cstt_pkg::STACK_DEPTH + 1, 1) : $urandom_range(4, 1);
					queue_tree(4'($urandom_range(15, 0)), dep, pick == 0);
					n += 2 * dep;
				end else begin
					a = r64();
					pending_calls.push_back(mk(1'($urandom_range(1, 0)),
						4'($urandom_range(15, 0)), a, 1'($urandom_range(1, 0)), r64()));
					n++;
				end
			end
			drain();
			set_trace(phase != 1);
			if (phase == 1) begin
				pending_calls.push_back(mk(cstt_pkg::REQ_ENTRY, 4'd2, r64(), 1'b1, r64()));
				drain();
				set_trace(1'b1);
			end
		end

		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end
endmodule
